>>> sv/dllc_pkg.sv
package dllc_pkg;

  localparam int MODE_W = 5;
  localparam int DATA_W = 32;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Operation codes carried in the mode field of a request.
  localparam mode_t OP_CLEAR      = 5'd0;
  localparam mode_t OP_INS_HEAD   = 5'd1;
  localparam mode_t OP_INS_TAIL   = 5'd2;
  localparam mode_t OP_CUR_HEAD   = 5'd3;
  localparam mode_t OP_CUR_TAIL   = 5'd4;
  localparam mode_t OP_RD_HEAD    = 5'd5;
  localparam mode_t OP_RD_TAIL    = 5'd6;
  localparam mode_t OP_DEL_HEAD   = 5'd7;
  localparam mode_t OP_DEL_TAIL   = 5'd8;
  localparam mode_t OP_DEL_AFTER  = 5'd9;
  localparam mode_t OP_DEL_BEFORE = 5'd10;
  localparam mode_t OP_INS_AFTER  = 5'd11;
  localparam mode_t OP_INS_BEFORE = 5'd12;
  localparam mode_t OP_RD_CUR     = 5'd13;
  localparam mode_t OP_WR_CUR     = 5'd14;
  localparam mode_t OP_STEP_NEXT  = 5'd15;
  localparam mode_t OP_STEP_PREV  = 5'd16;

endpackage

>>> sv/dllc_ifs.sv
interface dllc_cmd_if import dllc_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  data_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface dllc_rsp_if import dllc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t read_value;
  logic  error;
  logic  cursor_valid;
  logic  list_empty;

  modport source (output valid, output read_value, output error, output cursor_valid,
                  output list_empty, input ready);
  modport sink (input valid, input read_value, input error, input cursor_valid,
                input list_empty, output ready);
endinterface

>>> sv/doubly_linked_list_with_cursor_core.sv
// Channel  Direction  Payload                                      Handshake
// cmd      sink       mode, value                                  valid / ready
// rsp      source     read_value, error, cursor_valid, list_empty  valid / ready
//
// Every request runs through S_IDLE, S_RD2, S_WR1 and S_WR2: the accept state issues the
// first link and value reads, S_RD2 issues the read that depends on them, S_WR1 writes
// the link and value memories and S_WR2 the second link writes. A new request is taken
// only in S_IDLE. A waiting response does not block the next request; only a second
// finished response holds the sequencer in S_WR2 until the output register frees up.
// rst is synchronous and clears the list registers; the memories are never cleared.

module doubly_linked_list_with_cursor_core import dllc_pkg::*; #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  dllc_cmd_if.sink    cmd,
  dllc_rsp_if.source  rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef logic [IW-1:0]          idx_t;
  typedef logic [CW-1:0]          cnt_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  // One write to a link memory.
  typedef struct packed {
    logic we;
    idx_t addr;
    idx_t data;
  } link_wr_t;

  // Sequencer: accept and first read, dependent read, first write, second write.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD2  = 4'b0010,
    S_WR1  = 4'b0100,
    S_WR2  = 4'b1000
  } state_t;

  state_t state;

  // List bookkeeping registers.
  idx_t head_index, head_next;
  idx_t tail_index, tail_next;
  idx_t cursor_index, cursor_next;
  logic cursor_present, cursor_present_next;
  cnt_t entry_count, entry_count_next;
  idx_t free_head, free_head_next;
  logic free_nonempty, free_nonempty_next;
  cnt_t fresh_index, fresh_index_next;

  // Captured request and first read results.
  mode_t mode_r;
  val_t  val_r;
  val_t  val_in;
  idx_t  d_next1;
  idx_t  d_prev1;
  val_t  d_val;

  // Second write phase, held while the sequencer waits in its last cycle.
  link_wr_t nx_pend, pv_pend;
  link_wr_t nx_w1, pv_w1, nx_w2, pv_w2;
  logic     vl_w1_we;
  idx_t     vl_w1_addr;

  // Finished result.
  val_t  res_rd, res_rd_next;
  logic  res_err, res_err_next;
  data_t rd_out;

  logic  rsp_valid;
  data_t rsp_read_value;
  logic  rsp_error;
  logic  rsp_cursor_valid;
  logic  rsp_list_empty;

  // Memory ports.
  idx_t     nx_raddr, nx_rdata, pv_raddr, pv_rdata, vl_raddr;
  val_t     vl_rdata;
  link_wr_t nx_wr, pv_wr;
  logic     vl_we;

  // Allocation and free helpers.
  logic list_empty_now;
  logic alloc_ok;
  idx_t slot;
  logic do_alloc;
  logic do_free;
  idx_t free_idx;
  logic out_free;

  // The value store keeps VALUE_WIDTH bits; a read hands back its low bits, zero filled.
  if (VALUE_WIDTH > DATA_W) begin : g_wide
    assign val_in = {{(VALUE_WIDTH - DATA_W){cmd.value[DATA_W-1]}}, cmd.value};
    assign rd_out = res_rd[DATA_W-1:0];
  end else if (VALUE_WIDTH == DATA_W) begin : g_same
    assign val_in = cmd.value;
    assign rd_out = res_rd;
  end else begin : g_narrow
    assign val_in = cmd.value[VALUE_WIDTH-1:0];
    assign rd_out = {{(DATA_W - VALUE_WIDTH){1'b0}}, res_rd};
  end

  dllc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nx_wr.we),
    .waddr (nx_wr.addr),
    .wdata (nx_wr.data),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  dllc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pv_wr.we),
    .waddr (pv_wr.addr),
    .wdata (pv_wr.data),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  dllc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_w1_addr),
    .wdata (val_r),
    .raddr (vl_raddr),
    .rdata (vl_rdata)
  );

  assign cmd.ready = (state == S_IDLE);

  assign rsp.valid        = rsp_valid;
  assign rsp.read_value   = rsp_read_value;
  assign rsp.error        = rsp_error;
  assign rsp.cursor_valid = rsp_cursor_valid;
  assign rsp.list_empty   = rsp_list_empty;

  assign out_free       = !rsp_valid || rsp.ready;
  assign list_empty_now = (entry_count == '0);

  // A slot comes from the free list first, otherwise from the never used range.
  assign alloc_ok = free_nonempty || (fresh_index < CW'(CAPACITY));
  assign slot     = free_nonempty ? free_head : fresh_index[IW-1:0];

  // Read addresses. In the accept cycle they follow the incoming mode; in S_RD2
  // they follow the link that the first read returned, or the cursor for OP_INS_AFTER.
  always_comb begin
    nx_raddr = free_head;
    pv_raddr = tail_index;
    vl_raddr = head_index;
    if (state == S_IDLE) begin
      if (cmd.mode == OP_DEL_HEAD) begin
        nx_raddr = head_index;
      end else if (cmd.mode == OP_DEL_AFTER || cmd.mode == OP_STEP_NEXT) begin
        nx_raddr = cursor_index;
      end
      if (cmd.mode == OP_DEL_BEFORE || cmd.mode == OP_INS_BEFORE ||
          cmd.mode == OP_STEP_PREV) begin
        pv_raddr = cursor_index;
      end
      if (cmd.mode == OP_RD_TAIL) begin
        vl_raddr = tail_index;
      end else if (cmd.mode == OP_RD_CUR) begin
        vl_raddr = cursor_index;
      end
    end else if (state == S_RD2) begin
      if (mode_r == OP_DEL_AFTER) begin
        nx_raddr = nx_rdata;
      end else if (mode_r == OP_INS_AFTER) begin
        nx_raddr = cursor_index;
      end
      if (mode_r == OP_DEL_BEFORE) begin
        pv_raddr = pv_rdata;
      end
    end
  end

  // Operation decode in the first write cycle. The first read results sit in
  // d_next1, d_prev1 and d_val; the dependent read result is on the RAM outputs.
  always_comb begin
    head_next           = head_index;
    tail_next           = tail_index;
    cursor_next         = cursor_index;
    cursor_present_next = cursor_present;
    entry_count_next    = entry_count;
    free_head_next      = free_head;
    free_nonempty_next  = free_nonempty;
    fresh_index_next    = fresh_index;
    nx_w1               = '0;
    pv_w1               = '0;
    nx_w2               = '0;
    pv_w2               = '0;
    vl_w1_we            = 1'b0;
    vl_w1_addr          = cursor_index;
    res_rd_next         = '0;
    res_err_next        = 1'b0;
    do_alloc            = 1'b0;
    do_free             = 1'b0;
    free_idx            = head_index;

    unique case (mode_r)
      OP_CLEAR: begin
        head_next           = '0;
        tail_next           = '0;
        cursor_next         = '0;
        cursor_present_next = 1'b0;
        entry_count_next    = '0;
        free_head_next      = '0;
        free_nonempty_next  = 1'b0;
        fresh_index_next    = '0;
      end
      OP_INS_HEAD: begin
        if (!alloc_ok) begin
          res_err_next = 1'b1;
        end else begin
          do_alloc   = 1'b1;
          vl_w1_we   = 1'b1;
          vl_w1_addr = slot;
          nx_w1      = '{1'b1, slot, head_index};
          pv_w1      = '{1'b1, slot, idx_t'(0)};
          if (list_empty_now) begin
            tail_next = slot;
          end else begin
            pv_w2 = '{1'b1, head_index, slot};
          end
          head_next = slot;
        end
      end
      OP_INS_TAIL: begin
        if (!alloc_ok) begin
          res_err_next = 1'b1;
        end else begin
          do_alloc   = 1'b1;
          vl_w1_we   = 1'b1;
          vl_w1_addr = slot;
          pv_w1      = '{1'b1, slot, tail_index};
          nx_w1      = '{1'b1, slot, idx_t'(0)};
          if (list_empty_now) begin
            head_next = slot;
          end else begin
            nx_w2 = '{1'b1, tail_index, slot};
          end
          tail_next = slot;
        end
      end
      OP_CUR_HEAD: begin
        cursor_present_next = !list_empty_now;
        cursor_next         = head_index;
      end
      OP_CUR_TAIL: begin
        cursor_present_next = !list_empty_now;
        cursor_next         = tail_index;
      end
      OP_RD_HEAD, OP_RD_TAIL: begin
        if (list_empty_now) begin
          res_err_next = 1'b1;
        end else begin
          res_rd_next = d_val;
        end
      end
      OP_DEL_HEAD: begin
        if (!list_empty_now) begin
          if (cursor_present && cursor_index == head_index) begin
            cursor_present_next = 1'b0;
          end
          if (entry_count == CW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = d_next1;
            pv_w1     = '{1'b1, d_next1, idx_t'(0)};
          end
          nx_w1    = '{1'b1, head_index, free_head};
          do_free  = 1'b1;
          free_idx = head_index;
        end
      end
      OP_DEL_TAIL: begin
        if (!list_empty_now) begin
          if (cursor_present && cursor_index == tail_index) begin
            cursor_present_next = 1'b0;
          end
          if (entry_count == CW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            tail_next = d_prev1;
            nx_w1     = '{1'b1, d_prev1, idx_t'(0)};
          end
          nx_w2    = '{1'b1, tail_index, free_head};
          do_free  = 1'b1;
          free_idx = tail_index;
        end
      end
      OP_DEL_AFTER: begin
        // d_next1 is the victim, nx_rdata the entry after it.
        if (cursor_present && cursor_index != tail_index) begin
          nx_w1 = '{1'b1, cursor_index, nx_rdata};
          if (d_next1 == tail_index) begin
            tail_next = cursor_index;
          end else begin
            pv_w1 = '{1'b1, nx_rdata, cursor_index};
          end
          nx_w2    = '{1'b1, d_next1, free_head};
          do_free  = 1'b1;
          free_idx = d_next1;
        end
      end
      OP_DEL_BEFORE: begin
        // d_prev1 is the victim, pv_rdata the entry before it.
        if (cursor_present && cursor_index != head_index) begin
          pv_w1 = '{1'b1, cursor_index, pv_rdata};
          if (d_prev1 == head_index) begin
            head_next = cursor_index;
          end else begin
            nx_w1 = '{1'b1, pv_rdata, cursor_index};
          end
          nx_w2    = '{1'b1, d_prev1, free_head};
          do_free  = 1'b1;
          free_idx = d_prev1;
        end
      end
      OP_INS_AFTER: begin
        // nx_rdata is the entry that followed the cursor.
        if (cursor_present) begin
          if (!alloc_ok) begin
            res_err_next = 1'b1;
          end else begin
            do_alloc   = 1'b1;
            vl_w1_we   = 1'b1;
            vl_w1_addr = slot;
            pv_w1      = '{1'b1, slot, cursor_index};
            nx_w1      = '{1'b1, slot, nx_rdata};
            nx_w2      = '{1'b1, cursor_index, slot};
            if (cursor_index == tail_index) begin
              tail_next = slot;
            end else begin
              pv_w2 = '{1'b1, nx_rdata, slot};
            end
          end
        end
      end
      OP_INS_BEFORE: begin
        // d_prev1 is the entry that preceded the cursor.
        if (cursor_present) begin
          if (!alloc_ok) begin
            res_err_next = 1'b1;
          end else begin
            do_alloc   = 1'b1;
            vl_w1_we   = 1'b1;
            vl_w1_addr = slot;
            nx_w1      = '{1'b1, slot, cursor_index};
            pv_w1      = '{1'b1, slot, d_prev1};
            pv_w2      = '{1'b1, cursor_index, slot};
            if (cursor_index == head_index) begin
              head_next = slot;
            end else begin
              nx_w2 = '{1'b1, d_prev1, slot};
            end
          end
        end
      end
      OP_RD_CUR: begin
        if (!cursor_present) begin
          res_err_next = 1'b1;
        end else begin
          res_rd_next = d_val;
        end
      end
      OP_WR_CUR: begin
        vl_w1_we = cursor_present;
      end
      OP_STEP_NEXT: begin
        if (cursor_present) begin
          if (cursor_index == tail_index) begin
            cursor_present_next = 1'b0;
          end else begin
            cursor_next = d_next1;
          end
        end
      end
      OP_STEP_PREV: begin
        if (cursor_present) begin
          if (cursor_index == head_index) begin
            cursor_present_next = 1'b0;
          end else begin
            cursor_next = d_prev1;
          end
        end
      end
      default: begin
      end
    endcase

    // Taking a slot from the free list pops it; the list runs dry when only
    // one freed slot was left in it.
    if (do_alloc) begin
      entry_count_next = entry_count + 1'b1;
      if (free_nonempty) begin
        free_head_next     = d_next1;
        free_nonempty_next = (fresh_index - entry_count) > CW'(1);
      end else begin
        fresh_index_next = fresh_index + 1'b1;
      end
    end
    if (do_free) begin
      free_head_next     = free_idx;
      free_nonempty_next = 1'b1;
      entry_count_next   = entry_count - 1'b1;
    end
  end

  // Write ports: the decoded first writes in S_WR1, the held second writes in S_WR2.
  always_comb begin
    nx_wr = '0;
    pv_wr = '0;
    vl_we = 1'b0;
    if (state == S_WR1) begin
      nx_wr = nx_w1;
      pv_wr = pv_w1;
      vl_we = vl_w1_we;
    end else if (state == S_WR2) begin
      nx_wr = nx_pend;
      pv_wr = pv_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head_index     <= '0;
      tail_index     <= '0;
      cursor_index   <= '0;
      cursor_present <= 1'b0;
      entry_count    <= '0;
      free_head      <= '0;
      free_nonempty  <= 1'b0;
      fresh_index    <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_RD2;
          end
        end
        S_RD2: begin
          state <= S_WR1;
        end
        S_WR1: begin
          head_index     <= head_next;
          tail_index     <= tail_next;
          cursor_index   <= cursor_next;
          cursor_present <= cursor_present_next;
          entry_count    <= entry_count_next;
          free_head      <= free_head_next;
          free_nonempty  <= free_nonempty_next;
          fresh_index    <= fresh_index_next;
          state          <= S_WR2;
        end
        S_WR2: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (state == S_WR2 && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      mode_r <= cmd.mode;
      val_r  <= val_in;
    end
    if (state == S_RD2) begin
      d_next1 <= nx_rdata;
      d_prev1 <= pv_rdata;
      d_val   <= vl_rdata;
    end
    if (state == S_WR1) begin
      nx_pend <= nx_w2;
      pv_pend <= pv_w2;
      res_rd  <= res_rd_next;
      res_err <= res_err_next;
    end
    if (state == S_WR2 && out_free) begin
      rsp_read_value   <= rd_out;
      rsp_error        <= res_err;
      rsp_cursor_valid <= cursor_present;
      rsp_list_empty   <= list_empty_now;
    end
  end

endmodule

>>> sv/dllc_ram.sv
module dllc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/dllc_chk.sv
module dllc_chk import dllc_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  cmd_valid,
  input logic  cmd_ready,
  input logic  rsp_valid,
  input logic  rsp_ready,
  input data_t rsp_read_value,
  input logic  rsp_error,
  input logic  rsp_cursor_valid,
  input logic  rsp_list_empty
);

  // Requests taken but not yet answered.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, cmd_valid && cmd_ready} - {1'b0, rsp_valid && rsp_ready};
    end
  end

  // At most one request in work and one response waiting.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst) pending != 2'd3)
    else $error("more than two requests outstanding");

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without a request");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_error |-> rsp_read_value == '0)
    else $error("error response carries a value");

  a_empty_no_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_list_empty |-> !rsp_cursor_valid)
    else $error("cursor reported on an empty list");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
    else $error("stalled response changed");

endmodule

bind doubly_linked_list_with_cursor_core dllc_chk u_dllc_chk (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_read_value   (rsp.read_value),
  .rsp_error        (rsp.error),
  .rsp_cursor_valid (rsp.cursor_valid),
  .rsp_list_empty   (rsp.list_empty)
);
